>>> rtl/bfa_pkg.sv
package bfa_pkg;

  localparam int POOL_BITS = 4096;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = (POOL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = $clog2(MAP_WORDS);
  localparam int BIT_AW    = $clog2(WORD_BITS);
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 13;
  localparam int ST_W      = 2;
  localparam int CFG_W     = 13;
  localparam int CFG_IW    = 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ST_W-1:0]      status_t;
  typedef logic [WORD_AW-1:0]   waddr_t;
  typedef logic [BIT_AW-1:0]    bpos_t;

  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_EXHAUSTED   = 2'd1;
  localparam status_t ST_DOUBLE_FREE = 2'd2;
  localparam status_t ST_RANGE       = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IW-1:0] REG_INODE_SIZE = 1'd0;
  localparam logic [CFG_IW-1:0] REG_BLOCK_SIZE = 1'd1;

  // Bit position of a one-hot word
  function automatic bpos_t onehot_pos(input word_t oh);
    bpos_t p;
    p = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (oh[b]) begin
        p = p | bpos_t'(b);
      end
    end
    return p;
  endfunction

endpackage

>>> rtl/bfa_if.sv
interface bfa_req_if import bfa_pkg::*; ();
  logic valid;
  logic ready;
  logic kind;
  logic pool;
  idx_t item_index;

  modport source(output valid, output kind, output pool, output item_index, input ready);
  modport sink(input valid, input kind, input pool, input item_index, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  idx_t    result_index;
  cnt_t    free_left;

  modport source(output valid, output status, output result_index, output free_left,
                 input ready);
  modport sink(input valid, input status, input result_index, input free_left,
               output ready);
endinterface

>>> rtl/bfa_ram.sv
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bitmap_first_fit_allocator.sv
// Channel  Dir  Transfer             Payload
// in_ch    in   valid & ready        kind, pool, item_index
// out_ch   out  valid & ready        status, result_index, free_left
// cfg_*    in   cfg_we               cfg_index, cfg_data (pool size)
//
// Allocate scans the bitmap from word 0, one word read per cycle from the
// bitmap RAM shared by both pools. Free reads the word holding its index. An
// allocate on an empty pool or a free out of range returns without a bitmap write.
// Reset (rst_n low, synchronous) frees every item in both pools and sets both
// sizes to 4096; a size write re-initialises that pool at once.
// The result register holds while out_ch stalls; in_ch is ready in idle only.
module bitmap_first_fit_allocator import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bfa_req_if.sink           in_ch,
  bfa_rsp_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_FCHK  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam int RAM_AW = WORD_AW + 1;

  logic [2:0] state_r;
  logic       kind_r, pool_r;
  idx_t       idx_r;
  waddr_t     chk_r, last_w_r;
  word_t      tail_r, wd_r, mk_r;
  cnt_t       ino_size_r, blk_size_r, ino_cnt_r, blk_cnt_r;
  logic [1:0][MAP_WORDS-1:0] vld_r;

  status_t res_status_r;
  idx_t    res_index_r;
  cnt_t    res_free_r;

  logic    out_valid_r;
  status_t out_status_r;
  idx_t    out_index_r;
  cnt_t    out_free_r;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  word_t             ram_wdata, ram_rdata;

  cnt_t  size_sel, cnt_sel, lim, cfg_eff;
  word_t raw, mk, free_oh, tail, fbit;
  logic  acc;
  logic  out_load, out_take;

  bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(2 * MAP_WORDS)) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign acc      = in_ch.valid && in_ch.ready;
  assign size_sel = pool_r ? blk_size_r : ino_size_r;
  assign cnt_sel  = pool_r ? blk_cnt_r : ino_cnt_r;
  assign lim      = size_sel - cnt_t'(1);
  assign cfg_eff  = (cfg_data > CFG_W'(POOL_BITS)) ? cnt_t'(POOL_BITS) : cnt_t'(cfg_data);
  assign out_take = out_valid_r && out_ch.ready;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // Rows never written since the pool was set up read as all free
  assign raw     = vld_r[pool_r][chk_r] ? ram_rdata : '0;
  assign mk      = raw | ((chk_r == last_w_r) ? tail_r : '0);
  assign free_oh = ~mk_r & (mk_r + word_t'(1));
  assign fbit    = word_t'(1) << idx_r[BIT_AW-1:0];

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      tail[b] = (bpos_t'(b) > lim[BIT_AW-1:0]);
    end
  end

  always_comb begin
    ram_raddr = {pool_r, chk_r + waddr_t'(1)};
    if (state_r == S_START) begin
      ram_raddr = (kind_r == KIND_ALLOC) ? {pool_r, waddr_t'(0)}
                                         : {pool_r, idx_r[BIT_AW +: WORD_AW]};
    end
    ram_we    = 1'b0;
    ram_waddr = {pool_r, chk_r};
    ram_wdata = wd_r | free_oh;
    if (state_r == S_PICK) begin
      ram_we = 1'b1;
    end else if (state_r == S_FCHK && raw[idx_r[BIT_AW-1:0]]) begin
      ram_we    = 1'b1;
      ram_wdata = raw & ~fbit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ino_size_r  <= cnt_t'(POOL_BITS);
      blk_size_r  <= cnt_t'(POOL_BITS);
      ino_cnt_r   <= cnt_t'(POOL_BITS);
      blk_cnt_r   <= cnt_t'(POOL_BITS);
      vld_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INODE_SIZE: begin
            ino_size_r <= cfg_eff;
            ino_cnt_r  <= cfg_eff;
            vld_r[0]   <= '0;
          end
          REG_BLOCK_SIZE: begin
            blk_size_r <= cfg_eff;
            blk_cnt_r  <= cfg_eff;
            vld_r[1]   <= '0;
          end
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            kind_r  <= in_ch.kind;
            pool_r  <= in_ch.pool;
            idx_r   <= in_ch.item_index;
            state_r <= S_START;
          end
        end
        S_START: begin
          res_index_r <= idx_r;
          res_free_r  <= cnt_sel;
          last_w_r    <= lim[BIT_AW +: WORD_AW];
          tail_r      <= tail;
          if (kind_r == KIND_ALLOC) begin
            chk_r <= '0;
            if (cnt_sel == '0 || size_sel == '0) begin
              res_status_r <= ST_EXHAUSTED;
              state_r      <= S_FIN;
            end else begin
              state_r <= S_SCAN;
            end
          end else begin
            chk_r <= idx_r[BIT_AW +: WORD_AW];
            if (CNT_W'(idx_r) >= size_sel) begin
              res_status_r <= ST_RANGE;
              state_r      <= S_FIN;
            end else begin
              state_r <= S_FCHK;
            end
          end
        end
        S_SCAN: begin
          if (~mk != '0) begin
            wd_r    <= raw;
            mk_r    <= mk;
            state_r <= S_PICK;
          end else if (chk_r == last_w_r) begin
            res_status_r <= ST_EXHAUSTED;
            state_r      <= S_FIN;
          end else begin
            chk_r <= chk_r + waddr_t'(1);
          end
        end
        S_PICK: begin
          vld_r[pool_r][chk_r] <= 1'b1;
          res_status_r <= ST_OK;
          res_index_r  <= IDX_W'({chk_r, onehot_pos(free_oh)});
          res_free_r   <= cnt_sel - cnt_t'(1);
          if (pool_r) begin
            blk_cnt_r <= blk_cnt_r - cnt_t'(1);
          end else begin
            ino_cnt_r <= ino_cnt_r - cnt_t'(1);
          end
          state_r <= S_FIN;
        end
        S_FCHK: begin
          if (!raw[idx_r[BIT_AW-1:0]]) begin
            res_status_r <= ST_DOUBLE_FREE;
          end else begin
            vld_r[pool_r][chk_r] <= 1'b1;
            res_status_r <= ST_OK;
            res_free_r   <= cnt_sel + cnt_t'(1);
            if (pool_r) begin
              blk_cnt_r <= blk_cnt_r + cnt_t'(1);
            end else begin
              ino_cnt_r <= ino_cnt_r + cnt_t'(1);
            end
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          // Hold the result until the output register is free
          if (out_load) begin
            out_status_r <= res_status_r;
            out_index_r  <= res_index_r;
            out_free_r   <= res_free_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_index = out_index_r;
  assign out_ch.free_left    = out_free_r;

  a_ino_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ino_cnt_r <= ino_size_r)
    else $error("inode free count above pool size");

  a_blk_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    blk_cnt_r <= blk_size_r)
    else $error("block free count above pool size");

  a_pick_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |-> (~mk_r != '0))
    else $error("picked a word with no free bit");

  a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && kind_r == KIND_ALLOC && res_status_r == ST_OK)
      |-> (CNT_W'(res_index_r) < size_sel))
    else $error("allocated index beyond pool size");

endmodule

>>> tb/bitmap_first_fit_allocator_checker.sv
module bitmap_first_fit_allocator_checker import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bfa_req_if                in_ch,
  bfa_rsp_if                out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                fault_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t status;
    idx_t    result_index;
    cnt_t    free_left;
  } grant_t;

  grant_t             grants_due [$];
  logic [POOL_BITS-1:0] used_map [2];
  cnt_t               free_cnt [2];
  logic [CFG_W-1:0]   size_reg [2];
  int                 n_bad = 0;

  // Register values past the bitmap clip to its full width
  function automatic int unsigned usable_size(input logic [CFG_W-1:0] r);
    return (r > POOL_BITS) ? POOL_BITS : int'(r);
  endfunction

  function automatic void reinit_pool(input int p);
    used_map[p] = '0;
    free_cnt[p] = cnt_t'(usable_size(size_reg[p]));
  endfunction

  function automatic grant_t serve_request(input logic k, input logic p, input idx_t ix);
    grant_t      g;
    int unsigned lim;
    int          hit;
    lim            = usable_size(size_reg[p]);
    g.status       = ST_OK;
    g.result_index = ix;
    hit            = -1;
    if (k == KIND_ALLOC) begin
      if (free_cnt[p] == '0) begin
        g.status = ST_EXHAUSTED;
      end else begin
        for (int i = 0; i < int'(lim); i++) begin
          if (!used_map[p][i]) begin
            hit = i;
            break;
          end
        end
        // count says free but no clear bit: report exhausted, change nothing
        if (hit < 0) begin
          g.status = ST_EXHAUSTED;
        end else begin
          used_map[p][hit] = 1'b1;
          free_cnt[p]      = free_cnt[p] - 1'b1;
          g.result_index   = idx_t'(hit);
        end
      end
    end else if (ix >= lim) begin
      g.status = ST_RANGE;
    end else if (!used_map[p][ix]) begin
      g.status = ST_DOUBLE_FREE;
    end else begin
      used_map[p][ix] = 1'b0;
      free_cnt[p]     = free_cnt[p] + 1'b1;
    end
    g.free_left = free_cnt[p];
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      size_reg[0] = CFG_W'(POOL_BITS);
      size_reg[1] = CFG_W'(POOL_BITS);
      reinit_pool(0);
      reinit_pool(1);
      grants_due.delete();
    end else begin
      if (cfg_we) begin
        size_reg[cfg_index] = cfg_data;
        reinit_pool(int'(cfg_index));
      end
      // retire before predicting so a stray result cannot match a fresh request
      if (out_ch.valid && out_ch.ready) begin
        if (grants_due.size() == 0) begin
          $error("unexpected transfer: status %0d, result_index %0d, free_left %0d",
                 out_ch.status, out_ch.result_index, out_ch.free_left);
          n_bad++;
        end else begin
          want = grants_due.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            n_bad++;
          end
          if (out_ch.result_index !== want.result_index) begin
            $error("result_index: expected %0d, got %0d", want.result_index,
                   out_ch.result_index);
            n_bad++;
          end
          if (out_ch.free_left !== want.free_left) begin
            $error("free_left: expected %0d, got %0d", want.free_left, out_ch.free_left);
            n_bad++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        grants_due.push_back(serve_request(in_ch.kind, in_ch.pool, in_ch.item_index));
      end
    end
    // anything still outstanding counts against the run
    fault_count <= n_bad + grants_due.size();
  end

endmodule

>>> tb/bitmap_first_fit_allocator_test.sv
module bitmap_first_fit_allocator_test import bfa_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic POOL_INODE    = 1'b0;
  localparam logic POOL_BLOCK    = 1'b1;
  localparam int   IDLE_LIMIT    = 1000;
  localparam int   RANDOM_PHASES = 15;
  localparam int   OPS_PER_PHASE = 100;
  localparam int   DRAIN_CYCLES  = 80;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic [CFG_W-1:0]  size_now [2];
  bit                calm;
  int                n_in = 0;
  int                n_out = 0;
  int                n_cfg = 0;
  int                idle_cycles = 0;
  int                fault_count;

  bfa_req_if in_ch ();
  bfa_rsp_if out_ch ();

  bitmap_first_fit_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bitmap_first_fit_allocator_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fault_count (fault_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        n_in <= n_in + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_out <= n_out + 1;
      end
      if (cfg_we) begin
        n_cfg <= n_cfg + 1;
      end
    end
  end

  // Watchdog: give up after a long stretch without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("bitmap_first_fit_allocator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(POOL_BITS);
      3:       return CFG_W'($urandom_range(POOL_BITS + 1, 8191));
      4:       return CFG_W'(8191);
      5, 6, 7: return CFG_W'($urandom_range(2, 32));
      8:       return CFG_W'($urandom_range(33, 200));
      default: return CFG_W'($urandom_range(1, POOL_BITS));
    endcase
  endfunction

  // Aim frees at the low end where first fit packs allocations
  function automatic idx_t pick_index(input logic [CFG_W-1:0] sz);
    int unsigned eff;
    int unsigned lim;
    int unsigned r;
    eff = (sz > POOL_BITS) ? POOL_BITS : int'(sz);
    lim = (eff > 96) ? 96 : eff;
    r   = $urandom_range(0, 9);
    if (lim == 0 || r == 0) begin
      return idx_t'($urandom);
    end
    if (r == 1) begin
      return (eff < POOL_BITS) ? idx_t'(eff) : idx_t'(POOL_BITS - 1);
    end
    return idx_t'($urandom_range(0, lim - 1));
  endfunction

  task automatic send_op(input logic k, input logic p, input idx_t ix);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= k;
    in_ch.pool       <= p;
    in_ch.item_index <= ix;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Hold off until every request has been answered
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_in != n_out);
  endtask

  task automatic retune(input bit w_inode, input logic [CFG_W-1:0] s_inode,
                        input bit w_block, input logic [CFG_W-1:0] s_block);
    wait_drained();
    if (w_inode) begin
      cfg_we      <= 1'b1;
      cfg_index   <= REG_INODE_SIZE;
      cfg_data    <= s_inode;
      size_now[0] = s_inode;
      @(posedge clk);
    end
    if (w_block) begin
      cfg_we      <= 1'b1;
      cfg_index   <= REG_BLOCK_SIZE;
      cfg_data    <= s_block;
      size_now[1] = s_block;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver: stall a random number of cycles before each result, none while calm
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    int   which;
    int   alloc_pct;
    logic p;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_ALLOC;
    in_ch.pool       = POOL_INODE;
    in_ch.item_index = '0;
    cfg_we           = 1'b0;
    cfg_index        = REG_INODE_SIZE;
    cfg_data         = '0;
    rst_n            = 1'b0;
    calm             = 1'b0;
    size_now[0]      = CFG_W'(POOL_BITS);
    size_now[1]      = CFG_W'(POOL_BITS);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // first fit from index 0, reuse after free, double frees
    send_op(KIND_ALLOC, POOL_INODE, 12'hFFF);
    send_op(KIND_ALLOC, POOL_INODE, 12'h000);
    send_op(KIND_FREE,  POOL_INODE, 12'h000);
    send_op(KIND_FREE,  POOL_INODE, 12'h000);
    send_op(KIND_ALLOC, POOL_INODE, 12'h000);
    send_op(KIND_FREE,  POOL_INODE, 12'hFFF);
    send_op(KIND_ALLOC, POOL_BLOCK, 12'h000);
    send_op(KIND_FREE,  POOL_BLOCK, 12'hFFF);
    send_op(KIND_FREE,  POOL_BLOCK, 12'h000);

    // empty inode pool, oversized block register
    retune(1'b1, '0, 1'b1, CFG_W'(8191));
    send_op(KIND_ALLOC, POOL_INODE, 12'h555);
    send_op(KIND_FREE,  POOL_INODE, 12'h000);
    send_op(KIND_FREE,  POOL_BLOCK, 12'hFFF);
    send_op(KIND_ALLOC, POOL_BLOCK, 12'h000);

    // single-item inode pool, block register just past the bitmap
    retune(1'b1, CFG_W'(1), 1'b1, CFG_W'(POOL_BITS + 1));
    send_op(KIND_ALLOC, POOL_INODE, 12'hAAA);
    send_op(KIND_ALLOC, POOL_INODE, 12'hAAA);
    send_op(KIND_FREE,  POOL_INODE, 12'h001);
    send_op(KIND_FREE,  POOL_INODE, 12'h000);
    send_op(KIND_ALLOC, POOL_BLOCK, 12'h000);
    send_op(KIND_FREE,  POOL_BLOCK, 12'hFFF);

    // fill a two-item block pool and step over its edge
    retune(1'b0, '0, 1'b1, CFG_W'(2));
    send_op(KIND_ALLOC, POOL_BLOCK, 12'h000);
    send_op(KIND_ALLOC, POOL_BLOCK, 12'h000);
    send_op(KIND_ALLOC, POOL_BLOCK, 12'h7FF);
    send_op(KIND_FREE,  POOL_BLOCK, 12'h002);
    send_op(KIND_FREE,  POOL_BLOCK, 12'h001);
    send_op(KIND_ALLOC, POOL_BLOCK, 12'h800);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      which = $urandom_range(0, 2);
      retune(which != 2, pick_size(), which != 1, pick_size());
      calm      = ($urandom_range(0, 3) == 0);
      alloc_pct = $urandom_range(25, 85);
      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0) begin
          wait_drained();
        end
        p = logic'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < alloc_pct) begin
          send_op(KIND_ALLOC, p, idx_t'($urandom));
        end else begin
          send_op(KIND_FREE, p, pick_index(size_now[p]));
        end
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d allocate/free requests across %0d pool-size writes,", n_in, n_cfg);
    $display("including empty, single-item, clipped and full-width pools.");
    if (fault_count == 0) begin
      $display("bitmap_first_fit_allocator test passed");
    end else begin
      $display("bitmap_first_fit_allocator test failed");
    end
    $finish;
  end

endmodule
